// File: design/trie_ws_pkg.sv
// Package with the sizes, codes and shared types of the word trie.
`default_nettype none

package trie_ws_pkg;

  localparam int NODE_COUNT    = 1024;
  localparam int ALPHABET_SIZE = 26;

  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int SLOT_COUNT = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LETTER_W   = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [FREE_W-1:0]   free_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [LETTER_W-1:0] letter_t;

  // Access requests from the walk controller to the node store.
  typedef struct packed {
    logic  child_re;
    logic  child_we;
    slot_t child_addr;
    node_t child_wdata;
    logic  mark_re;
    logic  mark_we;
    node_t mark_addr;
    logic  mark_wdata;
  } store_req_t;

  // Registered read data and the clearing status of the node store.
  typedef struct packed {
    node_t child_rdata;
    logic  mark_rdata;
    logic  busy;
  } store_rsp_t;

endpackage

`default_nettype wire

// File: design/trie_ws_in_if.sv
// Channel interface that carries one letter of a word per transfer.
`default_nettype none

interface trie_ws_in_if
  import trie_ws_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    op;
  letter_t letter;
  logic    last;

  modport source (output valid, output op, output letter, output last, input ready);
  modport sink   (input valid, input op, input letter, input last, output ready);
endinterface

`default_nettype wire

// File: design/trie_ws_out_if.sv
// Channel interface that carries one word result per transfer.
`default_nettype none

interface trie_ws_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, output found, output status, input ready);
  modport sink   (input valid, input found, input status, output ready);
endinterface

`default_nettype wire

// File: design/trie_ws_store.sv
// Node store: child table and word-end marks with a clearing sweep after reset.
`default_nettype none

module trie_ws_store
  import trie_ws_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  store_req_t req_i,
  output store_rsp_t rsp_o
);

  node_t child_mem [SLOT_COUNT];
  logic  mark_mem  [NODE_COUNT];

  logic  busy_q, busy_d;
  slot_t clr_cnt_q, clr_cnt_d;
  node_t child_rdata_q;
  logic  mark_rdata_q;

  logic  child_we;
  slot_t child_waddr;
  node_t child_wdata;
  logic  mark_we;
  node_t mark_waddr;
  logic  mark_wdata;

  // While clearing, both memories take zeros at the sweep address. The mark
  // memory is shorter and simply wraps; repeated zero writes do no harm.
  always_comb begin
    busy_d    = busy_q;
    clr_cnt_d = clr_cnt_q;
    if (busy_q) begin
      child_we    = 1'b1;
      child_waddr = clr_cnt_q;
      child_wdata = '0;
      mark_we     = 1'b1;
      mark_waddr  = clr_cnt_q[NODE_W-1:0];
      mark_wdata  = 1'b0;
      clr_cnt_d   = clr_cnt_q + slot_t'(1);
      if (clr_cnt_q == slot_t'(SLOT_COUNT - 1)) begin
        busy_d = 1'b0;
      end
    end else begin
      child_we    = req_i.child_we;
      child_waddr = req_i.child_addr;
      child_wdata = req_i.child_wdata;
      mark_we     = req_i.mark_we;
      mark_waddr  = req_i.mark_addr;
      mark_wdata  = req_i.mark_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (req_i.child_re) begin
      child_rdata_q <= child_mem[req_i.child_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (req_i.mark_re) begin
      mark_rdata_q <= mark_mem[req_i.mark_addr];
    end
  end

  assign rsp_o.child_rdata = child_rdata_q;
  assign rsp_o.mark_rdata  = mark_rdata_q;
  assign rsp_o.busy        = busy_q;

endmodule

`default_nettype wire

// File: design/trie_word_insert_search_top.sv
// Top level of the word trie: letter walk, node allocation and result register.
//
//   channel | direction | payload              | transfer when
//   in_i    | sink      | op, letter, last     | valid && ready
//   out_o   | source    | found, status        | valid && ready
//
// For every letter the idle state issues the child-table read at (node *
// ALPHABET_SIZE + letter); the look state acts on the read data and writes a
// newly allocated child back. The last letter of a word then takes the mark
// state for the word-end mark, read or written at the node reached. After
// reset the node store sweeps its child table to zero, one entry a cycle, all
// SLOT_COUNT entries (26624 at the default sizes); in_i.ready stays low during
// the sweep. A waiting result does not block letters that give no result;
// only a second result waits in the mark state until out_o is free.
`default_nettype none

module trie_word_insert_search_top
  import trie_ws_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  trie_ws_in_if.sink    in_i,
  trie_ws_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_MARK = 3'b100
  } state_e;

  state_e state_q, state_d;

  node_t node_q, node_d;
  logic  miss_q, miss_d;
  logic  ovf_q, ovf_d;
  free_t free_q, free_d;
  logic  op_q, op_d;
  logic  last_q, last_d;
  logic  skip_q, skip_d;
  slot_t slot_q, slot_d;
  logic  ok_q, ok_d;

  logic  out_valid_q, out_valid_d;
  logic  found_q, found_d;
  logic  status_q, status_d;

  store_req_t req;
  store_rsp_t rsp;

  logic  in_xfer;
  logic  letter_bad;
  logic  out_free;
  slot_t slot_addr;
  node_t child;

  trie_ws_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_i.ready   = (state_q == ST_IDLE) && !rsp.busy;
  assign in_xfer      = in_i.valid && in_i.ready;
  assign letter_bad   = 32'(in_i.letter) >= 32'(ALPHABET_SIZE);
  assign slot_addr    = slot_t'(node_q) * slot_t'(ALPHABET_SIZE) + slot_t'(in_i.letter);
  assign child        = rsp.child_rdata;
  assign out_free     = !out_valid_q || out_o.ready;

  assign out_o.valid  = out_valid_q;
  assign out_o.found  = found_q;
  assign out_o.status = status_q;

  // Memory accesses never meet at one entry in the same cycle: a child-table
  // write happens in the look cycle and the next read is issued only on a
  // later letter, and the mark access of one word ends before the next word
  // can reach its own mark cycle.
  always_comb begin
    state_d     = state_q;
    node_d      = node_q;
    miss_d      = miss_q;
    ovf_d       = ovf_q;
    free_d      = free_q;
    op_d        = op_q;
    last_d      = last_q;
    skip_d      = skip_q;
    slot_d      = slot_q;
    ok_d        = ok_q;
    out_valid_d = out_valid_q && !out_o.ready;
    found_d     = found_q;
    status_d    = status_q;
    req         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d   = in_i.op;
          last_d = in_i.last;
          slot_d = slot_addr;
          // A word that has already failed, or a letter outside the alphabet,
          // leaves the walk untouched; a bad letter fails the word.
          skip_d = miss_q || ovf_q || letter_bad;
          if (!(miss_q || ovf_q) && letter_bad) begin
            miss_d = 1'b1;
          end
          req.child_re   = !(miss_q || ovf_q || letter_bad);
          req.child_addr = slot_addr;
          state_d        = ST_LOOK;
        end
      end

      ST_LOOK: begin
        if (!skip_q) begin
          if (child != '0) begin
            node_d = child;
          end else if (op_q == OP_SEARCH) begin
            miss_d = 1'b1;
          end else if (free_q == free_t'(NODE_COUNT)) begin
            ovf_d = 1'b1;
          end else begin
            req.child_we    = 1'b1;
            req.child_addr  = slot_q;
            req.child_wdata = free_q[NODE_W-1:0];
            node_d          = free_q[NODE_W-1:0];
            free_d          = free_q + free_t'(1);
          end
        end
        if (last_q) begin
          ok_d          = !(miss_d || ovf_d);
          req.mark_re   = (op_q == OP_SEARCH) && !(miss_d || ovf_d);
          req.mark_addr = node_d;
          state_d       = ST_MARK;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_MARK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ovf_q ? STATUS_EXHAUSTED : STATUS_OK;
          if (op_q == OP_SEARCH) begin
            found_d = ok_q && rsp.mark_rdata;
          end else begin
            found_d        = ok_q;
            req.mark_we    = ok_q;
            req.mark_addr  = node_q;
            req.mark_wdata = 1'b1;
          end
          // The walk returns to the root for the next word.
          node_d  = '0;
          miss_d  = 1'b0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_q      <= '0;
      miss_q      <= 1'b0;
      ovf_q       <= 1'b0;
      free_q      <= free_t'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_q      <= node_d;
      miss_q      <= miss_d;
      ovf_q       <= ovf_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    last_q   <= last_d;
    skip_q   <= skip_d;
    slot_q   <= slot_d;
    ok_q     <= ok_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire
